// ----- hw/rtl/cubic_bezier_forward_difference_unit_macros.svh -----
// Assertion macros for the cubic Bezier forward difference unit.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef CUBIC_BEZIER_FORWARD_DIFFERENCE_UNIT_MACROS_SVH
`define CUBIC_BEZIER_FORWARD_DIFFERENCE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CBFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

`define CBFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`else

`define CBFD_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define CBFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/cbfd_pkg.sv -----
// Shared types, constants and the rounding function of the Bezier unit.
// No dependencies; used by every module of the block.
package cbfd_pkg;

    localparam int COORD_W        = 16;
    localparam int LANES          = 3;
    localparam int CTRL_PTS       = 4;
    localparam int ACC_W          = 40;
    localparam int SHIFT_W        = 3;
    localparam int IDX_W          = 6;
    localparam int MAX_STEP_SHIFT = 5;
    localparam int STEP_SHIFT_RST = 4;
    localparam int IN_W           = COORD_W * LANES * CTRL_PTS;
    localparam int OUT_W          = 56;
    localparam int QDEPTH         = 2;
    localparam int QPTR_W         = $clog2(QDEPTH);

    typedef logic signed [COORD_W-1:0]          t_coord;
    typedef logic signed [ACC_W-1:0]            t_acc;
    typedef logic [LANES-1:0][ACC_W-1:0]        t_acc_vec;
    typedef logic [SHIFT_W-1:0]                 t_shift;
    typedef logic [IDX_W-1:0]                   t_idx;

    typedef struct packed {
        t_acc_vec p;
        t_acc_vec d1;
        t_acc_vec d2;
        t_acc_vec d3;
        t_shift   shift;
    } t_job;

    typedef enum logic [0:0] {
        BK_IDLE,
        BK_RUN
    } t_back_state;

    function automatic logic [3:0] triple_shift(t_shift s);
        return {1'b0, s} + {s, 1'b0};
    endfunction

    // round half up from 3*s fractional bits down to Q8.8
    function automatic t_coord round_point(t_acc v, t_shift s);
        logic [3:0] k;
        t_acc       bias;
        t_acc       sum;
        k    = triple_shift(s);
        bias = (s == '0) ? '0 : (t_acc'(1) <<< (k - 4'd1));
        sum  = v + bias;
        return t_coord'(sum >>> k);
    endfunction

endpackage

// ----- hw/rtl/cbfd_front.sv -----
// Front end: accepts control points, forms the polynomial coefficients and the
// initial forward differences, and hands a job to the queue. Uses cbfd_pkg.
module cbfd_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [cbfd_pkg::IN_W-1:0] i_data,
    input  cbfd_pkg::t_shift          i_shift,
    output logic                      o_push,
    output cbfd_pkg::t_job            o_job,
    input  logic                      i_q_ready
);

    logic               r_vld;
    cbfd_pkg::t_shift   r_shift;
    cbfd_pkg::t_acc     r_q0 [cbfd_pkg::LANES];
    cbfd_pkg::t_acc     r_a  [cbfd_pkg::LANES];
    cbfd_pkg::t_acc     r_b  [cbfd_pkg::LANES];
    cbfd_pkg::t_acc     r_c  [cbfd_pkg::LANES];

    cbfd_pkg::t_acc     w_q  [cbfd_pkg::CTRL_PTS][cbfd_pkg::LANES];
    cbfd_pkg::t_acc     n_a  [cbfd_pkg::LANES];
    cbfd_pkg::t_acc     n_b  [cbfd_pkg::LANES];
    cbfd_pkg::t_acc     n_c  [cbfd_pkg::LANES];
    logic               w_take;
    logic [3:0]         w_k3;
    logic [3:0]         w_k2;
    logic [3:0]         w_k1p;

    assign o_ready = !r_vld || i_q_ready;
    assign w_take  = i_valid && o_ready;
    assign o_push  = r_vld;

    always_comb begin
        cbfd_pkg::t_coord coord;
        cbfd_pkg::t_acc   diff;
        cbfd_pkg::t_acc   e;
        cbfd_pkg::t_acc   f;
        for (int pt = 0; pt < cbfd_pkg::CTRL_PTS; pt++) begin
            for (int k = 0; k < cbfd_pkg::LANES; k++) begin
                coord = i_data[(pt * cbfd_pkg::LANES + k) * cbfd_pkg::COORD_W +:
                               cbfd_pkg::COORD_W];
                w_q[pt][k] = cbfd_pkg::t_acc'(coord);
            end
        end
        for (int k = 0; k < cbfd_pkg::LANES; k++) begin
            diff    = w_q[1][k] - w_q[0][k];
            n_a[k]  = diff + (diff <<< 1);
            e       = w_q[0][k] - (w_q[1][k] <<< 1) + w_q[2][k];
            n_b[k]  = e + (e <<< 1);
            f       = w_q[1][k] - w_q[2][k];
            n_c[k]  = w_q[3][k] - w_q[0][k] + f + (f <<< 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_take) begin
            r_vld <= 1'b1;
        end else if (i_q_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_shift <= i_shift;
            for (int k = 0; k < cbfd_pkg::LANES; k++) begin
                r_q0[k] <= w_q[0][k];
                r_a[k]  <= n_a[k];
                r_b[k]  <= n_b[k];
                r_c[k]  <= n_c[k];
            end
        end
    end

    assign w_k3  = cbfd_pkg::triple_shift(r_shift);
    assign w_k2  = {r_shift, 1'b0};
    assign w_k1p = {1'b0, r_shift} + 4'd1;

    // p = P0<<3s, d1 = a<<2s + b<<s + c, d2 = b<<(s+1) + 6c, d3 = 6c
    always_comb begin
        cbfd_pkg::t_acc c6;
        o_job.shift = r_shift;
        for (int k = 0; k < cbfd_pkg::LANES; k++) begin
            c6          = (r_c[k] <<< 2) + (r_c[k] <<< 1);
            o_job.p[k]  = r_q0[k] <<< w_k3;
            o_job.d1[k] = (r_a[k] <<< w_k2) + (r_b[k] <<< r_shift) + r_c[k];
            o_job.d2[k] = (r_b[k] <<< w_k1p) + c6;
            o_job.d3[k] = c6;
        end
    end

endmodule

// ----- hw/rtl/cbfd_queue.sv -----
// Short job queue between front and back end, held in flip-flops.
// Depth is a power of two from cbfd_pkg; carries cbfd_pkg::t_job.
module cbfd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cbfd_pkg::t_job i_job,
    output logic           o_ready,
    output logic           o_valid,
    output cbfd_pkg::t_job o_job,
    input  logic           i_pop
);

    cbfd_pkg::t_job                  r_mem [cbfd_pkg::QDEPTH];
    logic [cbfd_pkg::QPTR_W-1:0]     r_wr;
    logic [cbfd_pkg::QPTR_W-1:0]     r_rd;
    logic [cbfd_pkg::QPTR_W:0]       r_count;
    logic                            w_wr;
    logic                            w_rd;

    assign o_ready = r_count != (cbfd_pkg::QPTR_W + 1)'(cbfd_pkg::QDEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd];
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (!w_wr && w_rd) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ----- hw/rtl/cbfd_back.sv -----
// Back end (uses cbfd_pkg, macros): runs the forward difference recurrence of
// one job; unless stalled, emits one rounded point per cycle to an output reg.
`include "cubic_bezier_forward_difference_unit_macros.svh"

module cbfd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  cbfd_pkg::t_job   i_job,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output cbfd_pkg::t_coord o_x,
    output cbfd_pkg::t_coord o_y,
    output cbfd_pkg::t_coord o_z,
    output cbfd_pkg::t_idx   o_idx,
    output logic             o_last
);

    cbfd_pkg::t_back_state r_state;
    cbfd_pkg::t_back_state n_state;
    cbfd_pkg::t_acc        r_p  [cbfd_pkg::LANES];
    cbfd_pkg::t_acc        r_d1 [cbfd_pkg::LANES];
    cbfd_pkg::t_acc        r_d2 [cbfd_pkg::LANES];
    cbfd_pkg::t_acc        r_d3 [cbfd_pkg::LANES];
    cbfd_pkg::t_shift      r_shift;
    cbfd_pkg::t_idx        r_n;
    cbfd_pkg::t_idx        r_idx;
    logic                  r_out_vld;
    logic                  n_out_vld;
    cbfd_pkg::t_coord      r_out_pt [cbfd_pkg::LANES];
    cbfd_pkg::t_idx        r_out_idx;
    logic                  r_out_last;
    logic                  w_emit;
    logic                  w_last;

    assign w_last = r_idx == r_n;

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        w_emit    = 1'b0;
        n_out_vld = r_out_vld && !i_ready;
        unique case (r_state)
            cbfd_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_state = cbfd_pkg::BK_RUN;
                end
            end
            cbfd_pkg::BK_RUN: begin
                if (!r_out_vld || i_ready) begin
                    w_emit    = 1'b1;
                    n_out_vld = 1'b1;
                    if (w_last) begin
                        n_state = cbfd_pkg::BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = cbfd_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cbfd_pkg::BK_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_shift <= i_job.shift;
            r_n     <= cbfd_pkg::t_idx'(1) << i_job.shift;
            r_idx   <= '0;
            for (int k = 0; k < cbfd_pkg::LANES; k++) begin
                r_p[k]  <= i_job.p[k];
                r_d1[k] <= i_job.d1[k];
                r_d2[k] <= i_job.d2[k];
                r_d3[k] <= i_job.d3[k];
            end
        end else if (w_emit) begin
            r_idx <= r_idx + 1'b1;
            for (int k = 0; k < cbfd_pkg::LANES; k++) begin
                r_p[k]  <= r_p[k] + r_d1[k];
                r_d1[k] <= r_d1[k] + r_d2[k];
                r_d2[k] <= r_d2[k] + r_d3[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            for (int k = 0; k < cbfd_pkg::LANES; k++) begin
                r_out_pt[k] <= cbfd_pkg::round_point(r_p[k], r_shift);
            end
            r_out_idx  <= r_idx;
            r_out_last <= w_last;
        end
    end

    assign o_valid = r_out_vld;
    assign o_x     = r_out_pt[0];
    assign o_y     = r_out_pt[1];
    assign o_z     = r_out_pt[2];
    assign o_idx   = r_out_idx;
    assign o_last  = r_out_last;

    `CBFD_ASSERT_NEXT(a_last_goes_idle, i_clk, i_rst_n, w_emit && w_last, r_state == cbfd_pkg::BK_IDLE)
    `CBFD_ASSERT_NEXT(a_idx_advances, i_clk, i_rst_n, w_emit && !w_last, r_idx == $past(r_idx) + 1'b1)
    `CBFD_ASSERT_IMP(a_last_not_first, i_clk, i_rst_n, r_out_vld && r_out_last, r_out_idx != '0)

endmodule

// ----- hw/rtl/cubic_bezier_forward_difference_unit.sv -----
// Each segment of four Q8.8 control points yields 2^s + 1 curve points, one per cycle
// while the output is not stalled, with the last marked on tlast; the back-end loop
// loads the job, then takes one accumulator step per point, and a two-entry queue lets the
// front end take and prepare the next segments meanwhile. s is step_shift, saturated to 5.
// Top level: holds the step_shift register and wires cbfd_front, cbfd_queue, cbfd_back.
// Depends on cbfd_pkg.
module cubic_bezier_forward_difference_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z
    input  logic [cbfd_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // point_x, point_y, point_z, sample_index, two zero bits
    output logic [cbfd_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                       m_axis_tlast,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [cbfd_pkg::SHIFT_W-1:0] i_cfg_data
);

    cbfd_pkg::t_shift r_step_shift;
    logic             w_push;
    cbfd_pkg::t_job   w_push_job;
    logic             w_q_ready;
    logic             w_q_valid;
    cbfd_pkg::t_job   w_head_job;
    logic             w_pop;
    cbfd_pkg::t_coord w_x;
    cbfd_pkg::t_coord w_y;
    cbfd_pkg::t_coord w_z;
    cbfd_pkg::t_idx   w_idx;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_shift <= cbfd_pkg::t_shift'(cbfd_pkg::STEP_SHIFT_RST);
        end else if (i_cfg_valid) begin
            r_step_shift <= (i_cfg_data > cbfd_pkg::t_shift'(cbfd_pkg::MAX_STEP_SHIFT))
                          ? cbfd_pkg::t_shift'(cbfd_pkg::MAX_STEP_SHIFT) : i_cfg_data;
        end
    end

    cbfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_data    (s_axis_tdata),
        .i_shift   (r_step_shift),
        .o_push    (w_push),
        .o_job     (w_push_job),
        .i_q_ready (w_q_ready)
    );

    cbfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_job   (w_head_job),
        .i_pop   (w_pop)
    );

    cbfd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_job     (w_head_job),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_x       (w_x),
        .o_y       (w_y),
        .o_z       (w_z),
        .o_idx     (w_idx),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, w_idx, w_z, w_y, w_x};

endmodule
